[rtl/triangle_primitive_assembly_core_macros.svh]
// assertion macros shared by the triangle primitive assembly rtl
// expects clk and arst_n in the scope where a macro is used
`ifndef TRIANGLE_PRIMITIVE_ASSEMBLY_CORE_MACROS_SVH
`define TRIANGLE_PRIMITIVE_ASSEMBLY_CORE_MACROS_SVH

// condition implies consequence in the same cycle
`define TPA_ASSERT_SAME(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define TPA_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

[rtl/tpa_pkg.sv]
// types and constants for the triangle primitive assembly block
// no dependencies
package tpa_pkg;

	localparam int OUT_W = 32;

	typedef enum logic [1:0] {
		MODE_LIST  = 2'd0,
		MODE_STRIP = 2'd1,
		MODE_FAN   = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	// one finished triangle, corners in winding order
	typedef struct packed {
		logic signed [OUT_W-1:0] first_x;
		logic signed [OUT_W-1:0] first_y;
		logic signed [OUT_W-1:0] first_z;
		logic signed [OUT_W-1:0] second_x;
		logic signed [OUT_W-1:0] second_y;
		logic signed [OUT_W-1:0] second_z;
		logic signed [OUT_W-1:0] third_x;
		logic signed [OUT_W-1:0] third_y;
		logic signed [OUT_W-1:0] third_z;
	} tri_t;

endpackage

[rtl/triangle_primitive_assembly_core.sv]
// top level of the triangle primitive assembly block
// depends on tpa_pkg, tpa_tri_skid and triangle_primitive_assembly_core_macros.svh
//
// Assembles a stream of vertices into triangles. A vertex word with start_primitive
// set opens a new primitive and latches prim_mode (list, strip or fan); until the
// first start the block assumes a triangle list. Up to two earlier vertices are held
// and one triangle word leaves whenever a new vertex completes a triangle: each group
// of three in a list, (first, previous, new) in a fan, and alternating winding in a
// strip. Unfinished list vertices are dropped at the next start, and mode three
// swallows every vertex until the next start. One vertex word is taken every cycle
// unless in_ready is low; a triangle appears on the output at the earliest in
// the cycle after the vertex that completes it, later when an older triangle is
// still waiting to be taken. The only limit on rate is the two-word output buffer:
// the input stalls only when output and skid registers both hold untaken triangles.
`include "triangle_primitive_assembly_core_macros.svh"

module triangle_primitive_assembly_core #(
	parameter int COORD_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// vertex channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        start_primitive,
	input  logic [1:0]  prim_mode,
	input  logic signed [31:0] vert_x,
	input  logic signed [31:0] vert_y,
	input  logic signed [31:0] vert_z,
	// triangle channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] first_x,
	output logic signed [31:0] first_y,
	output logic signed [31:0] first_z,
	output logic signed [31:0] second_x,
	output logic signed [31:0] second_y,
	output logic signed [31:0] second_z,
	output logic signed [31:0] third_x,
	output logic signed [31:0] third_y,
	output logic signed [31:0] third_z
);

	localparam int OW = tpa_pkg::OUT_W;

	// held vertices: slot a is the older (or the fan center), slot b the newer
	logic [COORD_WIDTH-1:0] held_a_q [3];
	logic [COORD_WIDTH-1:0] held_b_q [3];
	logic [1:0]             held_count_q;
	logic                   parity_q;
	tpa_pkg::mode_t         mode_q;

	logic                   accept;
	logic                   push;
	tpa_pkg::mode_t         eff_mode;
	logic [1:0]             eff_count;
	logic                   eff_parity;
	logic                   swap;
	logic [COORD_WIDTH-1:0] kept_v [3];
	logic [OW-1:0]          em_a [3];
	logic [OW-1:0]          em_b [3];
	logic [OW-1:0]          em_v [3];
	logic [31:0]            in_vert [3];
	tpa_pkg::tri_t          tri_new;
	tpa_pkg::tri_t          tri_out;

	assign accept = in_valid & in_ready;

	assign in_vert[0] = vert_x;
	assign in_vert[1] = vert_y;
	assign in_vert[2] = vert_z;

	// a start word resets the primitive before the vertex itself is used
	assign eff_mode   = start_primitive ? tpa_pkg::mode_t'(prim_mode) : mode_q;
	assign eff_count  = start_primitive ? 2'd0 : held_count_q;
	assign eff_parity = start_primitive ? 1'b0 : parity_q;

	// a triangle forms once two vertices are held, in any mode but the dead one
	assign push = accept && (eff_mode != tpa_pkg::MODE_NONE) && (eff_count == 2'd2);
	// odd strip triangles swap the two held corners
	assign swap = (eff_mode == tpa_pkg::MODE_STRIP) && eff_parity;

	// coordinates are stored at COORD_WIDTH bits and sign-extended back to 32 on output
	for (genvar k = 0; k < 3; k++) begin : g_coord
		assign kept_v[k] = COORD_WIDTH'($unsigned(in_vert[k]));
		if (COORD_WIDTH >= OW) begin : g_wide
			assign em_a[k] = held_a_q[k][OW-1:0];
			assign em_b[k] = held_b_q[k][OW-1:0];
			assign em_v[k] = kept_v[k][OW-1:0];
		end else begin : g_narrow
			assign em_a[k] = {{(OW-COORD_WIDTH){held_a_q[k][COORD_WIDTH-1]}}, held_a_q[k]};
			assign em_b[k] = {{(OW-COORD_WIDTH){held_b_q[k][COORD_WIDTH-1]}}, held_b_q[k]};
			assign em_v[k] = {{(OW-COORD_WIDTH){kept_v[k][COORD_WIDTH-1]}}, kept_v[k]};
		end
	end

	always_comb begin
		tri_new.first_x  = swap ? em_b[0] : em_a[0];
		tri_new.first_y  = swap ? em_b[1] : em_a[1];
		tri_new.first_z  = swap ? em_b[2] : em_a[2];
		tri_new.second_x = swap ? em_a[0] : em_b[0];
		tri_new.second_y = swap ? em_a[1] : em_b[1];
		tri_new.second_z = swap ? em_a[2] : em_b[2];
		tri_new.third_x  = em_v[0];
		tri_new.third_y  = em_v[1];
		tri_new.third_z  = em_v[2];
	end

	// control state: mode, fill count and strip parity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= tpa_pkg::MODE_LIST;
			held_count_q <= 2'd0;
			parity_q     <= 1'b0;
		end else if (accept) begin
			mode_q <= eff_mode;
			if (eff_mode == tpa_pkg::MODE_NONE) begin
				held_count_q <= eff_count;
				parity_q     <= eff_parity;
			end else if (eff_count != 2'd2) begin
				held_count_q <= eff_count + 2'd1;
				parity_q     <= eff_parity;
			end else begin
				case (eff_mode)
					tpa_pkg::MODE_LIST: begin
						held_count_q <= 2'd0;
						parity_q     <= eff_parity;
					end
					tpa_pkg::MODE_STRIP: begin
						held_count_q <= eff_count;
						parity_q     <= ~eff_parity;
					end
					default: begin
						held_count_q <= eff_count;
						parity_q     <= eff_parity;
					end
				endcase
			end
		end
	end

	// vertex slots: fill a then b, then shift (strip) or replace b (fan)
	always_ff @(posedge clk) begin
		if (accept && (eff_mode != tpa_pkg::MODE_NONE)) begin
			for (int k = 0; k < 3; k++) begin
				if (eff_count == 2'd0) begin
					held_a_q[k] <= kept_v[k];
				end else if (eff_count == 2'd1) begin
					held_b_q[k] <= kept_v[k];
				end else if (eff_mode == tpa_pkg::MODE_STRIP) begin
					held_a_q[k] <= held_b_q[k];
					held_b_q[k] <= kept_v[k];
				end else if (eff_mode == tpa_pkg::MODE_FAN) begin
					held_b_q[k] <= kept_v[k];
				end
			end
		end
	end

	// output register with skid; the input stalls only when both are full
	tpa_tri_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (tri_new),
		.can_push  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (tri_out)
	);

	assign first_x  = tri_out.first_x;
	assign first_y  = tri_out.first_y;
	assign first_z  = tri_out.first_z;
	assign second_x = tri_out.second_x;
	assign second_y = tri_out.second_y;
	assign second_z = tri_out.second_z;
	assign third_x  = tri_out.third_x;
	assign third_y  = tri_out.third_y;
	assign third_z  = tri_out.third_z;

	`TPA_ASSERT_SAME(a_count_range, 1'b1, held_count_q != 2'd3, "held count out of range")
	`TPA_ASSERT_NEXT(a_start_clears, accept && start_primitive, !parity_q && held_count_q != 2'd2, "start did not clear primitive")
	`TPA_ASSERT_NEXT(a_list_drains, push && eff_mode == tpa_pkg::MODE_LIST, held_count_q == 2'd0, "list triangle left vertices")

endmodule

[rtl/tpa_tri_skid.sv]
// two-entry output buffer for finished triangles (output register plus skid)
// depends on tpa_pkg and triangle_primitive_assembly_core_macros.svh
`include "triangle_primitive_assembly_core_macros.svh"

module tpa_tri_skid (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  tpa_pkg::tri_t push_data,
	output logic         can_push,
	output logic         out_valid,
	input  logic         out_ready,
	output tpa_pkg::tri_t out_data
);

	logic          out_valid_q;
	logic          skid_valid_q;
	tpa_pkg::tri_t out_data_q;
	tpa_pkg::tri_t skid_data_q;
	logic          pop;

	assign pop       = out_valid_q & out_ready;
	assign can_push  = ~skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (!push) begin
				out_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (push) begin
				out_data_q <= push_data;
			end
		end else if (push) begin
			if (!out_valid_q) begin
				out_data_q <= push_data;
			end else begin
				skid_data_q <= push_data;
			end
		end
	end

	`TPA_ASSERT_SAME(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with output empty")
	`TPA_ASSERT_NEXT(a_skid_kept, skid_valid_q && !out_ready, skid_valid_q, "skid word lost")
	`TPA_ASSERT_NEXT(a_push_lands, push && !out_valid_q, out_valid_q, "pushed word not shown")

endmodule

[tb/triangle_primitive_assembly_core_test.sv]
`timescale 1ns / 100ps
// self-checking testbench for triangle_primitive_assembly_core: vertex words in, triangle words out
// depends on tpa_pkg and the rtl of the block; predicts each triangle and checks every field

module triangle_primitive_assembly_core_test;

	localparam int COORD_W     = 32;
	localparam int HOLD_CYCLES = 60;
	localparam int CYCLE_LIMIT = 400000;

	// one held vertex at the block's coordinate width
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// vertex channel, driven from the start with known values
	logic in_valid = 1'b0;
	logic in_ready;
	logic start_primitive = 1'b0;
	logic [1:0] prim_mode = tpa_pkg::MODE_LIST;
	logic signed [31:0] vert_x = '0;
	logic signed [31:0] vert_y = '0;
	logic signed [31:0] vert_z = '0;

	// triangle channel
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] first_x, first_y, first_z;
	logic signed [31:0] second_x, second_y, second_z;
	logic signed [31:0] third_x, third_y, third_z;

	// assembler state as the testbench sees it
	tpa_pkg::mode_t asm_mode = tpa_pkg::MODE_LIST;
	int held_cnt = 0;
	bit wind_odd = 1'b0;
	vertex_t held_vtx[2];
	int vertices_used = 0;

	tpa_pkg::tri_t pending_triangles[$];

	// run control
	bit send_idle = 1'b1;
	bit take_idle = 1'b1;
	bit hold_off = 1'b0;
	event hold_start;
	int fault_count = 0;
	int cycle_count = 0;

	triangle_primitive_assembly_core #(
		.COORD_WIDTH(COORD_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.start_primitive(start_primitive),
		.prim_mode(prim_mode),
		.vert_x(vert_x),
		.vert_y(vert_y),
		.vert_z(vert_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.first_x(first_x),
		.first_y(first_y),
		.first_z(first_z),
		.second_x(second_x),
		.second_y(second_y),
		.second_z(second_z),
		.third_x(third_x),
		.third_y(third_y),
		.third_z(third_z)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("triangle_primitive_assembly_core_test: done, errors");
			$finish;
		end
	end

	function automatic void note_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("mismatch at %0t ns: %s", $time, msg);
	endfunction

	// held coordinates are sign-extended from the block width and cut to 32 bits
	function automatic logic [31:0] widen(input logic [COORD_W-1:0] c);
		logic signed [63:0] s;
		s = signed'(c);
		return s[31:0];
	endfunction

	// advance the assembler by one vertex; returns 1 when a triangle completes
	function automatic bit assemble_triangle(input bit start, input logic [1:0] mode_in,
			input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
			output tpa_pkg::tri_t result);
		vertex_t v, a, b, c0, c1;
		result = '0;
		// a start throws away whatever was held and restarts strip winding
		if (start) begin
			asm_mode = tpa_pkg::mode_t'(mode_in);
			held_cnt = 0;
			wind_odd = 1'b0;
		end
		v.x = x;
		v.y = y;
		v.z = z;
		// mode three swallows everything until the next start
		if (asm_mode == tpa_pkg::MODE_NONE)
			return 1'b0;
		vertices_used++;
		if (held_cnt < 2) begin
			held_vtx[held_cnt] = v;
			held_cnt++;
			return 1'b0;
		end
		a = held_vtx[0];
		b = held_vtx[1];
		// odd strip triangles swap the two held corners to keep the winding
		if (asm_mode == tpa_pkg::MODE_STRIP && wind_odd) begin
			c0 = b;
			c1 = a;
		end else begin
			c0 = a;
			c1 = b;
		end
		result.first_x  = widen(c0.x);
		result.first_y  = widen(c0.y);
		result.first_z  = widen(c0.z);
		result.second_x = widen(c1.x);
		result.second_y = widen(c1.y);
		result.second_z = widen(c1.z);
		result.third_x  = widen(v.x);
		result.third_y  = widen(v.y);
		result.third_z  = widen(v.z);
		case (asm_mode)
			tpa_pkg::MODE_LIST: begin
				held_cnt = 0;
			end
			tpa_pkg::MODE_STRIP: begin
				held_vtx[0] = b;
				held_vtx[1] = v;
				wind_odd = !wind_odd;
			end
			default: begin
				// fan keeps its first vertex and replaces the previous one
				held_vtx[1] = v;
			end
		endcase
		return 1'b1;
	endfunction

	// mix of extremes, small values around zero and full-range noise
	function automatic logic [31:0] pick_coord();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			4: return {{20{r[11]}}, r[11:0]};
			default: return r;
		endcase
	endfunction

	// one vertex word; valid stays up between words when the drawn gap is zero
	task automatic send_vertex(input bit start, input logic [1:0] mode,
			input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		int gap;
		tpa_pkg::tri_t made;
		gap = send_idle ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_primitive <= start;
		prim_mode <= mode;
		vert_x <= x;
		vert_y <= y;
		vert_z <= z;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (assemble_triangle(start, mode, x, y, z, made))
			pending_triangles.insert(pending_triangles.size(), made);
	endtask

	// a run of random vertices; the mode on words without a start is noise
	task automatic send_run(input bit opens, input logic [1:0] mode, input int count);
		for (int i = 0; i < count; i++)
			send_vertex(opens && i == 0, i == 0 ? mode : 2'($urandom_range(0, 3)),
				pick_coord(), pick_coord(), pick_coord());
	endtask

	// sender goes quiet until every predicted triangle has been taken
	task automatic pause_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_triangles.size() != 0)
			@(posedge clk);
	endtask

	// receiver: checks each triangle word against the oldest prediction
	task automatic check_triangle();
		tpa_pkg::tri_t want;
		logic [31:0] want_f[9];
		logic [31:0] got_f[9];
		string names[9];
		names = '{"first_x", "first_y", "first_z", "second_x", "second_y", "second_z",
			"third_x", "third_y", "third_z"};
		got_f = '{first_x, first_y, first_z, second_x, second_y, second_z,
			third_x, third_y, third_z};
		if (pending_triangles.size() == 0) begin
			note_fault($sformatf("triangle word with none pending: %h %h %h",
				first_x, second_x, third_x));
			return;
		end
		want = pending_triangles[0];
		pending_triangles.delete(0);
		want_f = '{want.first_x, want.first_y, want.first_z, want.second_x, want.second_y,
			want.second_z, want.third_x, want.third_y, want.third_z};
		for (int i = 0; i < 9; i++)
			if (got_f[i] !== want_f[i])
				note_fault($sformatf("%s expected %h, got %h", names[i], want_f[i], got_f[i]));
	endtask

	initial begin : take_triangles
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				check_triangle();
				stall_left = take_idle ? $urandom_range(0, 8) : 0;
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_ready <= !hold_off && stall_left == 0;
		end
	end

	// long receiver hold-off, counted here so the sender keeps pushing meanwhile
	initial begin : hold_output
		forever begin
			@(hold_start);
			hold_off <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_off <= 1'b0;
		end
	end

	// no start yet: the block must assume a triangle list; the modes on the words are ignored
	task automatic test_default_list();
		send_vertex(1'b0, tpa_pkg::MODE_FAN, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
		send_vertex(1'b0, tpa_pkg::MODE_STRIP, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
		send_vertex(1'b0, tpa_pkg::MODE_NONE, 32'hffff_ffff, 32'h0000_0000, 32'h8000_0000);
	endtask

	// one full list triangle, then two leftovers that the next start drops
	task automatic test_list_leftover();
		send_run(1'b1, tpa_pkg::MODE_LIST, 5);
	endtask

	// three strip triangles cover both windings
	task automatic test_strip_winding();
		send_run(1'b1, tpa_pkg::MODE_STRIP, 5);
	endtask

	task automatic test_fan_order();
		send_run(1'b1, tpa_pkg::MODE_FAN, 5);
	endtask

	// mode three eats vertices, even one carrying another mode without a start
	task automatic test_mode_three();
		send_vertex(1'b1, tpa_pkg::MODE_NONE, 32'h0000_0100, 32'h0000_0200, 32'h0000_0300);
		send_vertex(1'b0, tpa_pkg::MODE_STRIP, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_vertex(1'b0, tpa_pkg::MODE_LIST, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_run(1'b1, tpa_pkg::MODE_LIST, 3);
	endtask

	// mostly well-formed primitives with random content, some broken or ignored
	task automatic run_random_stream(input int target);
		int first_used;
		int r;
		first_used = vertices_used;
		while (vertices_used - first_used < target) begin
			r = $urandom_range(0, 99);
			// now and then the sender waits out the block, even mid-primitive
			if ($urandom_range(0, 39) == 0)
				pause_until_drained();
			if (r < 28)
				send_run(1'b1, tpa_pkg::MODE_LIST, 3 * $urandom_range(1, 5)
					+ ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0));
			else if (r < 58)
				send_run(1'b1, tpa_pkg::MODE_STRIP, $urandom_range(0, 5) == 0
					? $urandom_range(1, 2) : $urandom_range(3, 12));
			else if (r < 88)
				send_run(1'b1, tpa_pkg::MODE_FAN, $urandom_range(0, 5) == 0
					? $urandom_range(1, 2) : $urandom_range(3, 12));
			else if (r < 94)
				send_run(1'b1, tpa_pkg::MODE_NONE, $urandom_range(1, 4));
			else
				// words with no start simply extend whatever primitive is open
				send_run(1'b0, tpa_pkg::MODE_LIST, $urandom_range(1, 4));
		end
	endtask

	task automatic test_random_idle();
		send_idle = 1'b1;
		take_idle <= 1'b1;
		run_random_stream(600);
		pause_until_drained();
	endtask

	// back to back on both sides
	task automatic test_full_rate();
		send_idle = 1'b0;
		take_idle <= 1'b0;
		run_random_stream(300);
		pause_until_drained();
	endtask

	// receiver holds off while a fan streams in: the output buffer fills and in_ready drops
	task automatic test_output_backpressure();
		send_idle = 1'b0;
		take_idle <= 1'b0;
		-> hold_start;
		send_run(1'b1, tpa_pkg::MODE_FAN, 40);
		pause_until_drained();
	endtask

	// fast sender against a slow receiver, then the other way round
	task automatic test_mixed_rates();
		send_idle = 1'b0;
		take_idle <= 1'b1;
		run_random_stream(150);
		send_idle = 1'b1;
		take_idle <= 1'b0;
		run_random_stream(150);
		pause_until_drained();
	endtask

	initial begin : run_tests
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_default_list();
		test_list_leftover();
		test_strip_winding();
		test_fan_order();
		test_mode_three();
		test_random_idle();
		test_full_rate();
		test_output_backpressure();
		test_mixed_rates();

		// all words taken and checked; then wait on so that a stray triangle would still show
		pause_until_drained();
		repeat (10) @(posedge clk);
		if (fault_count == 0)
			$display("triangle_primitive_assembly_core_test: done, clean");
		else
			$display("triangle_primitive_assembly_core_test: done, errors");
		$finish;
	end

endmodule
